[rtl/eubw_pkg.sv]
// Shared types, constants and tables for the Euler body-to-world transform.
// Holds the CORDIC arctangent table and the coefficient multiply program.
// No dependencies.
package eubw_pkg;

  localparam int XY_W = 32;
  localparam int TAB_LEN = 24;
  localparam int OP_CNT = 15;
  localparam int VIS_CNT = 6;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint ONE_Q30 = 64'sd1073741824;

  localparam logic [1:0] ACT_ATT = 2'd0;
  localparam logic [1:0] ACT_POSE = 2'd1;
  localparam logic [1:0] ACT_VIS = 2'd2;

  typedef enum logic [3:0] {
    OPND_CR, OPND_SR, OPND_CP, OPND_SP, OPND_CY, OPND_SY,
    OPND_SRSP, OPND_CRSP, OPND_ONE
  } opnd_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_SRSP, DST_CRSP, DST_COEF, DST_WX, DST_WY
  } dest_t;

  typedef struct packed {
    opnd_t       a;
    opnd_t       b;
    logic        neg;
    logic        first;
    dest_t       dst;
    logic [3:0]  cidx;
  } op_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // R = Rz(yaw) * Ry(pitch) * Rx(roll), one rounded product per program step
  function automatic op_t att_op(input logic [3:0] idx);
    op_t o;
    unique case (idx)
      4'd0:  o = '{OPND_SR,   OPND_SP,  1'b0, 1'b1, DST_SRSP, 4'd0};
      4'd1:  o = '{OPND_CR,   OPND_SP,  1'b0, 1'b1, DST_CRSP, 4'd0};
      4'd2:  o = '{OPND_CP,   OPND_CY,  1'b0, 1'b1, DST_COEF, 4'd0};
      4'd3:  o = '{OPND_SRSP, OPND_CY,  1'b0, 1'b1, DST_NONE, 4'd0};
      4'd4:  o = '{OPND_CR,   OPND_SY,  1'b1, 1'b0, DST_COEF, 4'd1};
      4'd5:  o = '{OPND_CRSP, OPND_CY,  1'b0, 1'b1, DST_NONE, 4'd0};
      4'd6:  o = '{OPND_SR,   OPND_SY,  1'b0, 1'b0, DST_COEF, 4'd2};
      4'd7:  o = '{OPND_CP,   OPND_SY,  1'b0, 1'b1, DST_COEF, 4'd3};
      4'd8:  o = '{OPND_SRSP, OPND_SY,  1'b0, 1'b1, DST_NONE, 4'd0};
      4'd9:  o = '{OPND_CR,   OPND_CY,  1'b0, 1'b0, DST_COEF, 4'd4};
      4'd10: o = '{OPND_CRSP, OPND_SY,  1'b0, 1'b1, DST_NONE, 4'd0};
      4'd11: o = '{OPND_SR,   OPND_CY,  1'b1, 1'b0, DST_COEF, 4'd5};
      4'd12: o = '{OPND_SP,   OPND_ONE, 1'b1, 1'b1, DST_COEF, 4'd6};
      4'd13: o = '{OPND_SR,   OPND_CP,  1'b0, 1'b1, DST_COEF, 4'd7};
      4'd14: o = '{OPND_CR,   OPND_CP,  1'b0, 1'b1, DST_COEF, 4'd8};
      default: o = '{OPND_ONE, OPND_ONE, 1'b0, 1'b1, DST_NONE, 4'd0};
    endcase
    return o;
  endfunction

endpackage

[rtl/eubw_cordic.sv]
// Iterative rotation-mode CORDIC: cosine and sine of one angle, one step a cycle.
// Depends on eubw_pkg for the arctangent table and fixed-point constants.
module eubw_cordic #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [15:0]                 angle,
  output logic                               done,
  output logic signed [eubw_pkg::XY_W-1:0]   cos_val,
  output logic signed [eubw_pkg::XY_W-1:0]   sin_val
);
  import eubw_pkg::*;

  localparam int N = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int IW = $clog2(N);
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam int Z_W = 16 + SH + 3;
  localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(HALF_PI_Q30);
  localparam logic signed [Z_W-1:0] PI_Z = Z_W'(PI_Q30);
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  logic signed [XY_W-1:0] x, y, x_next, y_next, dx, dy;
  logic signed [Z_W-1:0]  z, z_next, za, at;
  logic [IW-1:0]          i;
  logic                   busy, neg;

  always_comb begin
    za = Z_W'(angle) <<< SH;
    dx = y >>> i;
    dy = x >>> i;
    at = Z_W'(atan_q30(5'(i)));
    if (!z[Z_W-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
        x    <= XY_W'(GAIN_Q30);
        y    <= '0;
        if (za > HALF_PI) begin
          z   <= za - PI_Z;
          neg <= 1'b1;
        end else if (za < -HALF_PI) begin
          z   <= za + PI_Z;
          neg <= 1'b1;
        end else begin
          z   <= za;
          neg <= 1'b0;
        end
      end else if (busy) begin
        z <= z_next;
        i <= i + 1'b1;
        if (i == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
          x    <= neg ? -x_next : x_next;
          y    <= neg ? -y_next : y_next;
        end else begin
          x <= x_next;
          y <= y_next;
        end
      end
    end
  end

  assign cos_val = x;
  assign sin_val = y;

endmodule

[rtl/euler_body_to_world_transform.sv]
// Top level of the Euler body-to-world transform: sequencer, shared multiplier,
// rotation matrix and pose storage. Depends on eubw_pkg and eubw_cordic.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | action, angles, pose, camera offset
//   out     | out_valid/out_stall| world_x_mm, world_y_mm, height_mm
//
// Attitude: three CORDIC runs, then 15 products on one 32x32 multiplier
// and a drain state. Vision: 6 products, then drain and push states.
// Pose and unused actions are taken in the idle state.
// Reset clears the matrix and pose to zero. in_stall is high while an item
// is in work; a held result stalls only a later vision item at its push.
module euler_body_to_world_transform #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int COEF_FRAC_BITS = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [23:0] pose_x_mm,
  input  logic signed [23:0] pose_y_mm,
  input  logic signed [14:0] cam_x_mm,
  input  logic signed [14:0] cam_y_mm,
  input  logic signed [14:0] cam_z_mm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [24:0] world_x_mm,
  output logic signed [24:0] world_y_mm,
  output logic signed [14:0] height_mm
);
  import eubw_pkg::*;

  localparam int C = COEF_FRAC_BITS;
  localparam int CW = C + 2;
  localparam int ACC_W = C + 25;
  localparam int PW = 2 * XY_W;
  localparam logic signed [PW-1:0] RND30 = PW'(64'sd536870912);
  localparam logic signed [ACC_W-1:0] RND_COEF = ACC_W'(64'sd1 <<< (29 - C));
  localparam logic signed [ACC_W-1:0] RND_ROW = ACC_W'(64'sd1 <<< (C - 1));
  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(64'sd1 <<< C);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CORD  = 6'b000010,
    S_MUL   = 6'b000100,
    S_VIS   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t state;
  logic [3:0] cnt;
  logic [1:0] k;
  logic       is_vis;
  logic       cord_start, cord_done;
  logic signed [15:0] ang [3];
  logic signed [15:0] cord_angle;
  logic signed [XY_W-1:0] cord_cos, cord_sin;
  logic signed [XY_W-1:0] cc [3];
  logic signed [XY_W-1:0] ss [3];
  logic signed [XY_W-1:0] srsp, crsp;
  logic signed [CW-1:0] coef [9];
  logic signed [23:0] pose_x, pose_y;
  logic signed [15:0] body [3];
  logic signed [14:0] height;
  logic signed [24:0] wx, wy;

  op_t att, iop, p_op;
  logic [1:0] bidx;
  logic signed [XY_W-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic p_vld;
  logic signed [ACC_W-1:0] acc, acc_new, base, term, r_att, coef_r, row_r;
  logic signed [CW-1:0] coef_sat;
  logic signed [24:0] pose_sel, world;

  function automatic logic signed [XY_W-1:0] opnd_val(
    input opnd_t o,
    input logic signed [XY_W-1:0] cr, sr, cp, sp, cy, sy, a_srsp, a_crsp
  );
    logic signed [XY_W-1:0] v;
    unique case (o)
      OPND_CR:   v = cr;
      OPND_SR:   v = sr;
      OPND_CP:   v = cp;
      OPND_SP:   v = sp;
      OPND_CY:   v = cy;
      OPND_SY:   v = sy;
      OPND_SRSP: v = a_srsp;
      OPND_CRSP: v = a_crsp;
      default:   v = XY_W'(ONE_Q30);
    endcase
    return v;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign cord_angle = ang[k];

  eubw_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .start(cord_start),
    .angle(cord_angle),
    .done(cord_done),
    .cos_val(cord_cos),
    .sin_val(cord_sin)
  );

  // issue stage
  always_comb begin
    att  = att_op(cnt);
    bidx = (cnt >= 4'd3) ? 2'(cnt - 4'd3) : cnt[1:0];
    if (state == S_VIS) begin
      iop.a     = OPND_ONE;
      iop.b     = OPND_ONE;
      iop.neg   = 1'b0;
      iop.first = (cnt == 4'd0) || (cnt == 4'd3);
      iop.dst   = (cnt == 4'd2) ? DST_WX : ((cnt == 4'd5) ? DST_WY : DST_NONE);
      iop.cidx  = cnt;
      mul_a     = XY_W'(coef[cnt]);
      mul_b     = XY_W'(body[bidx]);
    end else begin
      iop   = att;
      mul_a = opnd_val(att.a, cc[0], ss[0], cc[1], ss[1], cc[2], ss[2], srsp, crsp);
      mul_b = opnd_val(att.b, cc[0], ss[0], cc[1], ss[1], cc[2], ss[2], srsp, crsp);
    end
  end

  // accumulate stage
  always_comb begin
    r_att = ACC_W'((prod + RND30) >>> 30);
    base  = p_op.first ? '0 : acc;
    if (p_op.dst == DST_WX || p_op.dst == DST_WY || is_vis) begin
      term = ACC_W'(prod);
    end else begin
      term = p_op.neg ? -r_att : r_att;
    end
    acc_new = base + term;
    coef_r  = (acc_new + RND_COEF) >>> (30 - C);
    if (coef_r > LIM) begin
      coef_sat = CW'(LIM);
    end else if (coef_r < -LIM) begin
      coef_sat = CW'(-LIM);
    end else begin
      coef_sat = CW'(coef_r);
    end
    row_r    = (acc_new + RND_ROW) >>> C;
    pose_sel = (p_op.dst == DST_WX) ? 25'(pose_y) : 25'(pose_x);
    world    = row_r[24:0] + pose_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      k          <= '0;
      is_vis     <= 1'b0;
      cord_start <= 1'b0;
      p_vld      <= 1'b0;
      out_valid  <= 1'b0;
      pose_x     <= '0;
      pose_y     <= '0;
      for (int n = 0; n < 9; n++) begin
        coef[n] <= '0;
      end
    end else begin
      cord_start <= (state == S_IDLE && in_valid && action == ACT_ATT) ||
                    (state == S_CORD && cord_done && k != 2'd2);
      p_vld      <= (state == S_MUL || state == S_VIS);
      if (state == S_PUSH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (p_vld) begin
        acc <= acc_new;
        unique case (p_op.dst)
          DST_SRSP: srsp <= XY_W'(acc_new);
          DST_CRSP: crsp <= XY_W'(acc_new);
          DST_COEF: coef[p_op.cidx] <= coef_sat;
          DST_WX:   wx <= world;
          DST_WY:   wy <= world;
          default:  ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            priority if (action == ACT_ATT) begin
              ang[0]     <= roll_angle;
              ang[1]     <= pitch_angle;
              ang[2]     <= yaw_angle;
              k          <= '0;
              is_vis     <= 1'b0;
              state      <= S_CORD;
            end else if (action == ACT_POSE) begin
              pose_x <= pose_x_mm;
              pose_y <= pose_y_mm;
            end else if (action == ACT_VIS) begin
              body[0] <= -16'(cam_x_mm);
              body[1] <= -16'(cam_y_mm);
              body[2] <= 16'(cam_z_mm);
              height  <= cam_z_mm;
              cnt     <= '0;
              is_vis  <= 1'b1;
              state   <= S_VIS;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CORD: begin
          if (cord_done) begin
            cc[k] <= cord_cos;
            ss[k] <= cord_sin;
            if (k == 2'd2) begin
              cnt   <= '0;
              state <= S_MUL;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_MUL, S_VIS: begin
          prod  <= mul_a * mul_b;
          p_op  <= iop;
          cnt   <= cnt + 1'b1;
          if ((state == S_MUL && cnt == 4'(OP_CNT - 1)) ||
              (state == S_VIS && cnt == 4'(VIS_CNT - 1))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= is_vis ? S_PUSH : S_IDLE;
        end
        S_PUSH: begin
          if (!out_valid || !out_stall) begin
            world_x_mm <= wx;
            world_y_mm <= wy;
            height_mm  <= height;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mul_in_work: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> (state == S_MUL || state == S_VIS || state == S_DRAIN))
    else $error("multiplier result outside a product sequence");

  a_cordic_in_work: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> (state == S_CORD))
    else $error("CORDIC finished outside attitude work");

  a_out_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_PUSH)
    else $error("result transfer raised without a finished vision item");
`endif

endmodule
